// ===== hw/rtl/msfr_pkg.sv =====
package msfr_pkg;

  localparam int ID_W   = 22;
  localparam int BYTE_W = 8;

  typedef enum logic [1:0] {
    REPLY_ACK  = 2'd0,
    REPLY_NACK = 2'd1,
    REPLY_END  = 2'd2,
    REPLY_FULL = 2'd3
  } reply_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_FIND,
    S_UPDATE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic match;
    logic find;
    logic update;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic id_zero;
    logic will_emit;
    logic out_busy;
  } ctrl_stat_t;

endpackage

// ===== hw/rtl/msfr_bit_if.sv =====
interface msfr_bit_if import msfr_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] sender_id;
  logic            bit_value;

  modport source (output valid, output sender_id, output bit_value, input ready);
  modport sink   (input valid, input sender_id, input bit_value, output ready);
endinterface

// ===== hw/rtl/msfr_reply_if.sv =====
interface msfr_reply_if import msfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   target_id;
  reply_t            reply;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output target_id, output reply, output data_byte,
                  input ready);
  modport sink   (input valid, input target_id, input reply, input data_byte,
                  output ready);
endinterface

// ===== hw/rtl/multi_sender_frame_receiver.sv =====
// A bit transfer steps through capture, id match, slot pick with context read and
//   update; the update step loads its reply into the output register.
// A new bit is taken only once the last one is through and the block is idle; a bit
//   tagged with id zero is dropped after the id match. A reply held by the sink stalls
//   the next bit that produces a reply in its update step, and every bit behind it.
// Reset: synchronous, clears the entry valid bits, the output valid and the control
//   state; ids and frame contexts are not cleared, no clearing pass is run.
module multi_sender_frame_receiver import msfr_pkg::*; #(
  parameter int NUM_SENDERS = 8,
  parameter int FRAME_LEN   = 12,
  parameter int CHECK_BITS  = 4
) (
  input  logic           clk,
  input  logic           rst,
  msfr_bit_if.sink       rx,
  msfr_reply_if.source   tx
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // Sequencer: accept a bit transfer only when idle, then step through match,
  // slot pick and update. Hold in update while a due reply meets a full output.
  msfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (rx.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Context table, frame check and output register. Unknown ids take the
  // lowest free entry; a completed frame either ends the message (zero byte,
  // entry freed) or is acked/nacked by its popcount check and restarted.
  msfr_dpath #(
    .NUM_SENDERS (NUM_SENDERS),
    .FRAME_LEN   (FRAME_LEN),
    .CHECK_BITS  (CHECK_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_id     (rx.sender_id),
    .in_bit    (rx.bit_value),
    .out_ready (tx.ready),
    .out_valid (tx.valid),
    .out_id    (tx.target_id),
    .out_reply (tx.reply),
    .out_byte  (tx.data_byte)
  );

endmodule

// ===== hw/rtl/msfr_ctrl.sv =====
module msfr_ctrl import msfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_MATCH;
        end
      end
      S_MATCH: begin
        // drop bits tagged with id zero
        if (stat.id_zero) begin
          state_next = S_IDLE;
        end else begin
          cmd.match  = 1'b1;
          state_next = S_FIND;
        end
      end
      S_FIND: begin
        cmd.find   = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        // hold while a reply is due and the output register is still full
        if (!(stat.will_emit && stat.out_busy)) begin
          cmd.update = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/msfr_dpath.sv =====
module msfr_dpath import msfr_pkg::*; #(
  parameter int NUM_SENDERS = 8,
  parameter int FRAME_LEN   = 12,
  parameter int CHECK_BITS  = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_cmd_t         cmd,
  output ctrl_stat_t        stat,
  input  logic [ID_W-1:0]   in_id,
  input  logic              in_bit,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [ID_W-1:0]   out_id,
  output reply_t            out_reply,
  output logic [BYTE_W-1:0] out_byte
);

  localparam int SLOT_W = (NUM_SENDERS > 1) ? $clog2(NUM_SENDERS) : 1;
  localparam int CNT_W  = $clog2(FRAME_LEN + 1);
  localparam int MEM_W  = FRAME_LEN + CNT_W;

  function automatic logic [SLOT_W-1:0] lowest_set(input logic [NUM_SENDERS-1:0] v);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = NUM_SENDERS - 1; i >= 0; i--) begin
      if (v[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [3:0] ones8(input logic [BYTE_W-1:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

  // captured item
  logic [ID_W-1:0] cur_id;
  logic            cur_bit;

  // context table: ids and valid bits in flops, frame state in a memory
  logic [NUM_SENDERS-1:0] entry_valid;
  logic [ID_W-1:0]        entry_id [NUM_SENDERS];
  logic [MEM_W-1:0]       ctx_mem  [NUM_SENDERS];
  logic [MEM_W-1:0]       ctx_rd;

  logic [NUM_SENDERS-1:0] hit_vec;
  logic [NUM_SENDERS-1:0] free_vec;
  logic [SLOT_W-1:0]      slot_enc;
  logic [SLOT_W-1:0]      slot;
  logic                   is_new;
  logic                   is_full;

  logic [FRAME_LEN-1:0]   old_shift;
  logic [CNT_W-1:0]       old_cnt;
  logic [FRAME_LEN-1:0]   shift_new;
  logic [CNT_W-1:0]       cnt_new;
  logic                   frame_done;
  logic [FRAME_LEN+7:0]   shift_ext;
  logic [BYTE_W-1:0]      frame_byte;
  logic [BYTE_W-1:0]      frame_chk;
  logic                   byte_zero;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_id  <= in_id;
      cur_bit <= in_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      for (int i = 0; i < NUM_SENDERS; i++) begin
        hit_vec[i]  <= entry_valid[i] && (entry_id[i] == cur_id);
        free_vec[i] <= !entry_valid[i];
      end
    end
  end

  assign slot_enc = (|hit_vec) ? lowest_set(hit_vec) : lowest_set(free_vec);

  always_ff @(posedge clk) begin
    if (cmd.find) begin
      slot    <= slot_enc;
      is_new  <= ~|hit_vec;
      is_full <= ~|hit_vec && ~|free_vec;
    end
  end

  // context memory: read in the find step, written back in the update step
  always_ff @(posedge clk) begin
    if (cmd.find) begin
      ctx_rd <= ctx_mem[slot_enc];
    end
    if (cmd.update && !is_full) begin
      ctx_mem[slot] <= frame_done ? '0 : {shift_new, cnt_new};
    end
  end

  assign old_shift  = is_new ? '0 : ctx_rd[MEM_W-1:CNT_W];
  assign old_cnt    = is_new ? '0 : ctx_rd[CNT_W-1:0];
  assign shift_new  = {old_shift[FRAME_LEN-2:0], cur_bit};
  assign cnt_new    = old_cnt + CNT_W'(1);
  assign frame_done = (cnt_new == CNT_W'(FRAME_LEN));
  assign shift_ext  = {8'b0, shift_new};
  assign frame_byte = shift_ext[CHECK_BITS +: BYTE_W];
  assign frame_chk  = BYTE_W'(shift_new[CHECK_BITS-1:0]);
  assign byte_zero  = (frame_byte == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.update && !is_full) begin
      if (is_new) begin
        entry_valid[slot] <= 1'b1;
      end
      if (frame_done && byte_zero) begin
        entry_valid[slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && !is_full && is_new) begin
      entry_id[slot] <= cur_id;
    end
  end

  assign stat.id_zero   = (cur_id == '0);
  assign stat.will_emit = is_full || frame_done;
  assign stat.out_busy  = out_valid && !out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update && stat.will_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && stat.will_emit) begin
      out_id <= cur_id;
      if (is_full) begin
        out_reply <= REPLY_FULL;
        out_byte  <= '0;
      end else if (byte_zero) begin
        out_reply <= REPLY_END;
        out_byte  <= '0;
      end else begin
        out_reply <= (BYTE_W'(ones8(frame_byte)) == frame_chk) ? REPLY_ACK : REPLY_NACK;
        out_byte  <= frame_byte;
      end
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.match, cmd.find, cmd.update}))
    else $error("more than one datapath command active");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.update && is_full |-> &entry_valid)
    else $error("table full reported with a free entry");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.update && stat.will_emit |-> !(out_valid && !out_ready))
    else $error("reply loaded over an untaken reply");

  a_end_frees: assert property (@(posedge clk) disable iff (rst)
    cmd.update && !is_full && frame_done && byte_zero |=> !entry_valid[$past(slot)])
    else $error("entry not freed after end of message");

endmodule

// ===== tb/sv/msfr_reply_checker.sv =====
module msfr_reply_checker import msfr_pkg::*; #(
  parameter int NUM_SENDERS = 8,
  parameter int FRAME_LEN   = 12,
  parameter int CHECK_BITS  = 4
) (
  input  logic  clk,
  input  logic  rst,
  msfr_bit_if   bit_ch,
  msfr_reply_if reply_ch,
  output int    fail_count,
  output int    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ID_W-1:0]   target_id;
    reply_t            reply;
    logic [BYTE_W-1:0] data_byte;
  } reply_item_t;

  logic                 slot_used  [NUM_SENDERS];
  logic [ID_W-1:0]      slot_id    [NUM_SENDERS];
  logic [FRAME_LEN-1:0] slot_frame [NUM_SENDERS];
  int                   slot_bits  [NUM_SENDERS];

  reply_item_t replies_due [$];
  reply_item_t want;

  // Shift one bit into the sender's context and queue the reply it causes, if any.
  function automatic void absorb_bit(input logic [ID_W-1:0] id, input logic b);
    int                    i;
    int                    hit;
    int                    spare;
    logic [31:0]           wide;
    logic [BYTE_W-1:0]     data;
    logic [CHECK_BITS-1:0] tally;
    reply_item_t           item;
    hit   = -1;
    spare = -1;
    if (id == '0) return;
    for (i = 0; i < NUM_SENDERS; i++) begin
      if (slot_used[i]) begin
        if (hit < 0 && slot_id[i] == id) hit = i;
      end else if (spare < 0) begin
        spare = i;
      end
    end
    if (hit < 0) begin
      if (spare < 0) begin
        item = '{target_id: id, reply: REPLY_FULL, data_byte: '0};
        replies_due.push_back(item);
        return;
      end
      hit             = spare;
      slot_used[hit]  = 1'b1;
      slot_id[hit]    = id;
      slot_frame[hit] = '0;
      slot_bits[hit]  = 0;
    end
    slot_frame[hit] = {slot_frame[hit][FRAME_LEN-2:0], b};
    slot_bits[hit]++;
    if (slot_bits[hit] < FRAME_LEN) return;
    wide  = 32'(slot_frame[hit]) >> CHECK_BITS;
    data  = wide[BYTE_W-1:0];
    tally = slot_frame[hit][CHECK_BITS-1:0];
    slot_frame[hit] = '0;
    slot_bits[hit]  = 0;
    if (data == '0) begin
      slot_used[hit] = 1'b0;
      item = '{target_id: id, reply: REPLY_END, data_byte: '0};
    end else if ($countones(data) == tally) begin
      item = '{target_id: id, reply: REPLY_ACK, data_byte: data};
    end else begin
      item = '{target_id: id, reply: REPLY_NACK, data_byte: data};
    end
    replies_due.push_back(item);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      replies_due.delete();
    end else begin
      if (reply_ch.valid === 1'b1 && reply_ch.ready === 1'b1) begin
        if (replies_due.size() == 0) begin
          $error("reply to %0h with no reply pending", reply_ch.target_id);
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          if (reply_ch.target_id !== want.target_id) begin
            $error("target_id: expected %0h, got %0h", want.target_id, reply_ch.target_id);
            fail_count++;
          end
          if (reply_ch.reply !== want.reply) begin
            $error("reply: expected %0d, got %0d", want.reply, reply_ch.reply);
            fail_count++;
          end
          if (reply_ch.data_byte !== want.data_byte) begin
            $error("data_byte: expected %0h, got %0h", want.data_byte, reply_ch.data_byte);
            fail_count++;
          end
        end
      end
      if (bit_ch.valid === 1'b1 && bit_ch.ready === 1'b1)
        absorb_bit(bit_ch.sender_id, bit_ch.bit_value);
    end
    pending = replies_due.size();
  end

endmodule

// ===== tb/sv/tb_multi_sender_frame_receiver.sv =====
module tb_multi_sender_frame_receiver import msfr_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SENDERS  = 8;
  localparam int FRAME_LEN    = 12;
  localparam int CHECK_BITS   = 4;
  localparam int RANDOM_ITEMS = 900;
  localparam int HOLD_CYCLES  = 300;
  // Longest message: three data frames plus the end frame.
  localparam int MSG_W        = 4 * FRAME_LEN;

  logic clk;
  logic rst;

  msfr_bit_if   bit_ch ();
  msfr_reply_if reply_ch ();

  int fail_count;
  int pending;

  // Idle odds in percent, set per phase by the stimulus.
  int send_idle_pct;
  int recv_idle_pct;
  // Bumped by the stimulus to ask the reply side for one long hold-off.
  int hold_reqs;
  // Transfers with a nonzero sender id.
  int bits_sent;

  // Two fixed ids carry stray bits between messages. Their bit counts are kept
  // so that the stray entries can be realigned and freed before a table fill.
  logic [ID_W-1:0] noise_ids [2];
  int              noise_len [2];

  // Messages in flight, one per sender, sent MSB first.
  logic [ID_W-1:0]  stream_id   [NUM_SENDERS];
  logic [MSG_W-1:0] stream_data [NUM_SENDERS];
  int               stream_left [NUM_SENDERS];

  multi_sender_frame_receiver #(
    .NUM_SENDERS (NUM_SENDERS),
    .FRAME_LEN   (FRAME_LEN),
    .CHECK_BITS  (CHECK_BITS)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .rx  (bit_ch),
    .tx  (reply_ch)
  );

  msfr_reply_checker #(
    .NUM_SENDERS (NUM_SENDERS),
    .FRAME_LEN   (FRAME_LEN),
    .CHECK_BITS  (CHECK_BITS)
  ) reply_check (
    .clk        (clk),
    .rst        (rst),
    .bit_ch     (bit_ch),
    .reply_ch   (reply_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs; a correct run ends far earlier.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Reply side: drop ready at random, or hold it low for a long stretch when
  // asked, so that the reply register stays full and the bit input backs up.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left      = 0;
    hold_seen      = 0;
    reply_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        reply_ch.ready <= 1'b0;
      end else begin
        if (hold_left == 0 && hold_seen != hold_reqs) begin
          hold_seen = hold_reqs;
          hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          hold_left--;
          reply_ch.ready <= 1'b0;
        end else begin
          reply_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
      end
    end
  end

  // Offer one bit, idling first at random, and hold it until the transfer.
  task automatic drive_bit(input logic [ID_W-1:0] id, input logic b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      bit_ch.valid <= 1'b0;
      @(negedge clk);
    end
    bit_ch.valid     <= 1'b1;
    bit_ch.sender_id <= id;
    bit_ch.bit_value <= b;
    do @(posedge clk); while (bit_ch.ready !== 1'b1);
    if (id != '0) bits_sent++;
  endtask

  // Send the low n bits of w, MSB first.
  task automatic send_word(input logic [ID_W-1:0] id, input logic [FRAME_LEN-1:0] w,
                           input int n);
    int i;
    for (i = n - 1; i >= 0; i--) drive_bit(id, w[i]);
  endtask

  // Build a frame: byte above, check count below, right or random.
  function automatic logic [FRAME_LEN-1:0] make_frame(input logic [7:0] b, input bit good);
    logic [CHECK_BITS-1:0] chk;
    if (good) chk = CHECK_BITS'($countones(b));
    else      chk = CHECK_BITS'($urandom_range(0, 2 ** CHECK_BITS - 1));
    return {b, chk};
  endfunction

  // Draw a nonzero id that no loaded stream and no stray id uses.
  function automatic logic [ID_W-1:0] fresh_id(input int k);
    logic [ID_W-1:0] id;
    bit              clash;
    int              j;
    do begin
      id    = ID_W'($urandom_range(1, 2 ** ID_W - 1));
      clash = (id == noise_ids[0]) || (id == noise_ids[1]);
      for (j = 0; j < k; j++) if (stream_id[j] == id) clash = 1'b1;
    end while (clash);
    return id;
  endfunction

  // Load k messages: up to max_data data frames with nonzero bytes, then the
  // zero-byte frame that ends the message and frees the entry.
  task automatic load_streams(input int k, input int max_data);
    int s;
    int nd;
    for (s = 0; s < k; s++) begin
      stream_id[s]   = fresh_id(s);
      stream_data[s] = '0;
      stream_left[s] = 0;
      nd = $urandom_range(0, max_data);
      repeat (nd) begin
        stream_data[s] = (stream_data[s] << FRAME_LEN)
                       | make_frame(8'($urandom_range(1, 255)), $urandom_range(0, 99) < 65);
        stream_left[s] += FRAME_LEN;
      end
      stream_data[s] = (stream_data[s] << FRAME_LEN) | make_frame(8'h00, 1'b0);
      stream_left[s] += FRAME_LEN;
    end
  endtask

  // Stray traffic: either a bit with id zero, or a bit on one of the stray ids.
  task automatic send_noise();
    int j;
    if ($urandom_range(0, 1)) begin
      drive_bit('0, 1'($urandom_range(0, 1)));
    end else begin
      j = $urandom_range(0, 1);
      drive_bit(noise_ids[j], 1'($urandom_range(0, 1)));
      noise_len[j]++;
    end
  endtask

  // Interleave the k messages bit by bit at random until each has only keep
  // bits left; mix in stray traffic at the given odds.
  task automatic run_streams(input int k, input int noise_pct, input int keep);
    int s;
    int j;
    int pick;
    do begin
      pick = -1;
      s    = $urandom_range(0, k - 1);
      for (j = 0; j < k; j++)
        if (pick < 0 && stream_left[(s + j) % k] > keep) pick = (s + j) % k;
      if (pick >= 0) begin
        if ($urandom_range(0, 99) < noise_pct) send_noise();
        stream_left[pick]--;
        drive_bit(stream_id[pick], stream_data[pick][stream_left[pick]]);
      end
    end while (pick >= 0);
  endtask

  // Pad each stray id to a frame boundary, then send a zero frame: whatever
  // the padded frame did, the zero frame leaves the id without an entry.
  task automatic clear_noise();
    int j;
    for (j = 0; j < 2; j++) begin
      send_word(noise_ids[j], '0, (FRAME_LEN - noise_len[j] % FRAME_LEN) % FRAME_LEN);
      send_word(noise_ids[j], '0, FRAME_LEN);
      noise_len[j] = 0;
    end
  endtask

  // Fill every entry, hold back the last bit of each message, hit the full
  // table with unknown ids, then finish the messages so all entries free up.
  task automatic overflow_burst();
    clear_noise();
    load_streams(NUM_SENDERS, 1);
    run_streams(NUM_SENDERS, 0, 1);
    repeat ($urandom_range(1, 4))
      drive_bit(fresh_id(NUM_SENDERS), 1'($urandom_range(0, 1)));
    run_streams(NUM_SENDERS, 0, 0);
  endtask

  // Drop valid and wait until every queued reply has been seen.
  task automatic wait_for_replies();
    @(negedge clk);
    bit_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int phase;
    int random_base;
    int k;
    rst              = 1'b1;
    bit_ch.valid     = 1'b0;
    bit_ch.sender_id = '0;
    bit_ch.bit_value = 1'b0;
    send_idle_pct    = 11;
    recv_idle_pct    = 63;
    hold_reqs        = 0;
    bits_sent        = 0;
    noise_ids[0]     = 22'h3FFFFF;
    noise_ids[1]     = 22'h000001;
    noise_len[0]     = 0;
    noise_len[1]     = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: a bit with id zero is dropped silently; the top id sends an
    // all-ones byte with a matching count (ack); the bottom id ends a message
    // with a zero byte and a nonzero count (end).
    drive_bit('0, 1'b1);
    send_word(noise_ids[0], {8'hFF, 4'd8}, FRAME_LEN);
    noise_len[0] += FRAME_LEN;
    send_word(noise_ids[1], {8'h00, 4'hF}, FRAME_LEN);
    noise_len[1] += FRAME_LEN;

    // Random: three phases of idling, each opening with a full-table burst.
    random_base = bits_sent;
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 63 : 0;
      recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 11 : 0;
      if (phase != 0) wait_for_replies();
      // Stall the reply side while the burst keeps the input busy.
      if (phase == 2) hold_reqs++;
      overflow_burst();
      while (bits_sent - random_base < (phase + 1) * RANDOM_ITEMS / 3) begin
        if ($urandom_range(0, 99) < 15) begin
          overflow_burst();
        end else begin
          k = $urandom_range(1, NUM_SENDERS - 2);
          load_streams(k, 3);
          run_streams(k, 8, 0);
        end
      end
    end

    wait_for_replies();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== multi_sender_frame_receiver.f =====
hw/rtl/msfr_pkg.sv
hw/rtl/msfr_bit_if.sv
hw/rtl/msfr_reply_if.sv
hw/rtl/msfr_ctrl.sv
hw/rtl/msfr_dpath.sv
hw/rtl/multi_sender_frame_receiver.sv
tb/sv/msfr_reply_checker.sv
tb/sv/tb_multi_sender_frame_receiver.sv
